>>> design/b2w_pkg.sv
package b2w_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 31;
  localparam int unsigned WbW    = 5;
  localparam int unsigned BufW   = 39;
  localparam int unsigned CntW   = 6;

  localparam logic [WbW-1:0]  WbReset = WbW'(8);
  localparam logic [CntW-1:0] ByteCnt = CntW'(ByteW);

  // One-hot sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  // Result of one pass through the shared extract unit
  typedef struct packed {
    logic [WordW-1:0] word;   // low w bits of the buffer
    logic [BufW-1:0]  rest;   // buffer shifted down by w
    logic [CntW-1:0]  rem;    // count minus w
    logic             emit;   // count > w: a regular word is available
    logic             more;   // another regular word follows this one
  } step_res_t;

endpackage

>>> design/b2w_if.sv
interface b2w_in_if;
  logic                          valid;
  logic                          ready;
  logic [b2w_pkg::ByteW-1:0]     data_byte;
  logic                          stream_last;

  modport source (output valid, data_byte, stream_last, input ready);
  modport sink   (input valid, data_byte, stream_last, output ready);
endinterface

interface b2w_out_if;
  logic                          valid;
  logic                          ready;
  logic [b2w_pkg::WordW-1:0]     word;
  logic                          run_last;
  logic                          flush_word;

  modport source (output valid, word, run_last, flush_word, input ready);
  modport sink   (input valid, word, run_last, flush_word, output ready);
endinterface

>>> design/byte_to_word_bit_repacker_core.sv
// Byte to word bit repacker, 8 to N bit gearbox.
// Input channel in_i carries one byte per beat plus a stream_last flag. Each byte
// is appended above the bits already buffered, LSB first. Output channel out_o
// carries words of word_bits bits (1..31, 0 acts as 1), taken from the bottom of
// the buffer while strictly more than word_bits bits are held. On a last byte the
// remaining bits leave as one zero-padded flush word and the buffer empties.
// run_last marks the final word caused by a byte.
// Timing: a byte is accepted while the sequencer is idle, then the shared extract
// unit yields one word per cycle while the output register is free; a byte that
// produces no word returns the sequencer to idle. in_i.ready is high only while
// the sequencer is idle. The buffer and then the output register hold each word.
// A stalled receiver holds the output register; the sequencer waits on it, so
// back-pressure reaches the input through the sequencer.
// Writing cfg_wdata_i (while idle) sets word_bits and drops any partial word.
// Reset empties the buffer, sets word_bits to 8 and clears the output valid.
module byte_to_word_bit_repacker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  b2w_in_if.sink                        in_i,
  b2w_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [b2w_pkg::WbW-1:0]       cfg_wdata_i
);

  b2w_pkg::state_e                state_q, state_d;
  logic [b2w_pkg::WbW-1:0]        wb_q;
  logic [b2w_pkg::WbW-1:0]        width_eff;
  logic [b2w_pkg::BufW-1:0]       buf_q, buf_d;
  logic [b2w_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                           last_q, last_d;

  logic                           out_valid_q, out_valid_d;
  logic [b2w_pkg::WordW-1:0]      out_word_q, out_word_d;
  logic                           out_rlast_q, out_rlast_d;
  logic                           out_flush_q, out_flush_d;

  logic                           in_beat;
  logic                           out_free;
  logic                           load;
  b2w_pkg::step_res_t             step;

  // A width of zero behaves as one
  assign width_eff = (wb_q == '0) ? b2w_pkg::WbW'(1) : wb_q;

  assign in_i.ready = (state_q == b2w_pkg::ST_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;
  // Output register can take a new word when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_o.ready;

  b2w_step_unit u_step (
    .buf_i   (buf_q),
    .cnt_i   (cnt_q),
    .width_i (width_eff),
    .res_o   (step)
  );

  always_comb begin
    state_d     = state_q;
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    load        = 1'b0;
    out_word_d  = out_word_q;
    out_rlast_d = out_rlast_q;
    out_flush_d = out_flush_q;

    unique case (state_q)
      b2w_pkg::ST_IDLE: begin
        if (in_beat) begin
          // Append the byte above the buffered bits
          buf_d   = buf_q | (b2w_pkg::BufW'(in_i.data_byte) << cnt_q);
          cnt_d   = cnt_q + b2w_pkg::ByteCnt;
          last_d  = in_i.stream_last;
          state_d = b2w_pkg::ST_RUN;
        end
      end
      b2w_pkg::ST_RUN: begin
        if (out_free) begin
          if (step.emit) begin
            // Regular word: shift it out of the buffer
            load        = 1'b1;
            out_word_d  = step.word;
            out_rlast_d = !step.more && !last_q;
            out_flush_d = 1'b0;
            buf_d       = step.rest;
            cnt_d       = step.rem;
            if (!step.more && !last_q) begin
              state_d = b2w_pkg::ST_IDLE;
            end
          end else if (last_q) begin
            // Flush the remaining bits, zero-padded, and empty the buffer
            load        = 1'b1;
            out_word_d  = step.word;
            out_rlast_d = 1'b1;
            out_flush_d = 1'b1;
            buf_d       = '0;
            cnt_d       = '0;
            state_d     = b2w_pkg::ST_IDLE;
          end else begin
            // Byte completed no word
            state_d = b2w_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = b2w_pkg::ST_IDLE;
      end
    endcase

    // A width change drops any partly assembled word
    if (cfg_we_i) begin
      buf_d = '0;
      cnt_d = '0;
    end
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= b2w_pkg::ST_IDLE;
      wb_q        <= b2w_pkg::WbReset;
      buf_q       <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        wb_q <= cfg_wdata_i;
      end
    end
  end

  // Output payload: hold unless a new word is loaded
  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    out_rlast_q <= out_rlast_d;
    out_flush_q <= out_flush_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.word       = out_word_q;
  assign out_o.run_last   = out_rlast_q;
  assign out_o.flush_word = out_flush_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= b2w_pkg::CntW'(b2w_pkg::BufW))
    else $error("bit count beyond buffer width");

  a_idle_below_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == b2w_pkg::ST_IDLE) |-> (cnt_q <= b2w_pkg::CntW'(width_eff)))
    else $error("idle with a complete word still buffered");

  a_clean_above_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_q >> cnt_q) == '0)
    else $error("stale bits above the bit count");

  a_flush_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_flush_q) |-> out_rlast_q)
    else $error("flush word not marked as last of its byte");

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && !cfg_we_i) |=> (state_q == b2w_pkg::ST_RUN && cnt_q >= b2w_pkg::ByteCnt))
    else $error("accepted byte did not start a run");
`endif

endmodule

>>> design/b2w_step_unit.sv
module b2w_step_unit (
  input  logic [b2w_pkg::BufW-1:0]  buf_i,
  input  logic [b2w_pkg::CntW-1:0]  cnt_i,
  input  logic [b2w_pkg::WbW-1:0]   width_i,
  output b2w_pkg::step_res_t        res_o
);

  logic [b2w_pkg::WordW-1:0] mask;
  logic [b2w_pkg::CntW-1:0]  width_ext;

  // At the full width of 31 the shift wraps to zero and the mask becomes all ones.
  assign mask      = (b2w_pkg::WordW'(1) << width_i) - b2w_pkg::WordW'(1);
  assign width_ext = b2w_pkg::CntW'(width_i);

  always_comb begin
    res_o.word = buf_i[b2w_pkg::WordW-1:0] & mask;
    res_o.rest = buf_i >> width_i;
    res_o.rem  = cnt_i - width_ext;
    res_o.emit = cnt_i > width_ext;
    res_o.more = (cnt_i - width_ext) > width_ext;
  end

endmodule

>>> sim/byte_to_word_bit_repacker_checker.sv
module byte_to_word_bit_repacker_checker
  import b2w_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  b2w_in_if                 in_ch,
  b2w_out_if                out_ch,
  input  logic              cfg_we_i,
  input  logic [WbW-1:0]    cfg_wdata_i,
  output int unsigned       mismatch_cnt_o,
  output int unsigned       pending_o
);

  localparam int unsigned MaxWords  = 9;
  localparam int unsigned ShowLimit = 10;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             run_last;
    logic             flush_word;
  } word_beat_t;

  logic [WbW-1:0]  width_q;
  logic [BufW-1:0] bits_q;
  logic [CntW-1:0] fill_q;
  word_beat_t      expected_words[$];
  int unsigned     mismatches = 0;

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
  end

  // Append one byte to the bit buffer and queue the words it releases.
  task automatic repack_byte(input logic [ByteW-1:0] data, input logic last);
    word_beat_t      words[MaxWords];
    int unsigned     n;
    int unsigned     w;
    int unsigned     i;
    logic [BufW-1:0] mask;
    n    = 0;
    w    = (width_q == '0) ? 1 : int'(width_q);
    mask = (BufW'(1) << w) - BufW'(1);
    bits_q = bits_q | (BufW'(data) << fill_q);
    fill_q = fill_q + ByteCnt;
    // Only strictly more than w bits release a word; an exact fill waits.
    while (fill_q > CntW'(w) && n < MaxWords) begin
      words[n] = '{word: WordW'(bits_q & mask), run_last: 1'b0, flush_word: 1'b0};
      n++;
      bits_q = bits_q >> w;
      fill_q = fill_q - CntW'(w);
    end
    if (last) begin
      if (fill_q != '0 && n < MaxWords) begin
        words[n] = '{word: WordW'(bits_q & mask), run_last: 1'b0, flush_word: 1'b1};
        n++;
      end
      bits_q = '0;
      fill_q = '0;
    end
    for (i = 0; i < n; i++) begin
      words[i].run_last = (i == n - 1);
      expected_words.push_back(words[i]);
    end
  endtask

  task automatic compare_word(input logic [WordW-1:0] word, input logic run_last,
                              input logic flush_word);
    word_beat_t want;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= ShowLimit)
        $display("unexpected word beat: word=%h run_last=%0b flush_word=%0b",
                 word, run_last, flush_word);
    end else begin
      want = expected_words.pop_front();
      if (word !== want.word || run_last !== want.run_last ||
          flush_word !== want.flush_word) begin
        mismatches++;
        if (mismatches <= ShowLimit)
          $display("word beat mismatch: expected word=%h run_last=%0b flush_word=%0b, %s",
                   want.word, want.run_last, want.flush_word,
                   $sformatf("got word=%h run_last=%0b flush_word=%0b",
                             word, run_last, flush_word));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q = WbReset;
      bits_q  = '0;
      fill_q  = '0;
      expected_words.delete();
    end else begin
      // A width write drops any partly assembled word.
      if (cfg_we_i) begin
        width_q = cfg_wdata_i;
        bits_q  = '0;
        fill_q  = '0;
      end
      if (out_ch.valid && out_ch.ready)
        compare_word(out_ch.word, out_ch.run_last, out_ch.flush_word);
      if (in_ch.valid && in_ch.ready)
        repack_byte(in_ch.data_byte, in_ch.stream_last);
    end
    pending_o      <= expected_words.size();
    mismatch_cnt_o <= mismatches;
  end

endmodule

>>> sim/byte_to_word_bit_repacker_core_test.sv
module byte_to_word_bit_repacker_core_test;
  import b2w_pkg::*;

  // Settle time after the last expected word: one byte may still be in the
  // sequencer without producing a word, plus margin.
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned TotalBytes   = 430;
  localparam int unsigned PhaseBytes   = 40;

  typedef enum int unsigned {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  b2w_in_if  in_ch ();
  b2w_out_if out_ch ();

  logic            cfg_we;
  logic [WbW-1:0]  cfg_wdata;
  int unsigned     mismatches;
  int unsigned     pending;

  // Stimulus control shared with the receiver process.
  rx_mode_e        rx_mode     = RX_ALWAYS;
  int unsigned     hold_cycles = 0;
  logic [7:0]      stall_pattern = 8'b1101_0110;

  int unsigned     bytes_sent  = 0;
  int unsigned     burst_left  = 1;
  bit              gapless     = 1'b1;

  byte_to_word_bit_repacker_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  byte_to_word_bit_repacker_checker repack_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  // Word receiver: stall on its own schedule. A requested hold-off is
  // counted down here, one cycle per edge, while the sender keeps offering.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_ch.ready <= 1'b1;
          RX_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: begin
            out_ch.ready  <= stall_pattern[0];
            stall_pattern  = {stall_pattern[0], stall_pattern[7:1]};
          end
          default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Pick a byte value, weighting the all-zero and all-one extremes.
  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one beat and hold it until accepted; then maybe open a gap.
  task automatic send_byte(input logic [ByteW-1:0] data, input logic last);
    int unsigned gap;
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= data;
    in_ch.stream_last <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = gapless ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop valid, wait for every expected word, then let the sequencer settle.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the word width; only called while the block is idle.
  task automatic write_width(input logic [WbW-1:0] width);
    cfg_wdata <= width;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Send a run of random bytes; close it with stream_last if asked.
  task automatic send_stream(input int unsigned len, input bit close);
    int unsigned i;
    for (i = 0; i < len; i++)
      send_byte(pick_byte(), close && (i == len - 1));
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_start;
    logic [WbW-1:0] width;

    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.stream_last <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, receiver always ready.
    // Reset width of 8: an exact fill holds its byte, the next byte
    // releases it, and the last byte flushes the remainder.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    drain_block();

    // Width 1: leave one bit behind, so the next last byte yields
    // eight regular words plus the flush.
    write_width(WbW'(1));
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'hFF, 1'b1);
    drain_block();

    // Widest word: four bytes to release the first one.
    write_width(WbW'(31));
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);
    drain_block();

    // Zero width acts as one bit.
    write_width(WbW'(0));
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    drain_block();

    // Random phases: new width, receiver mode and idling per phase.
    phase = 0;
    while (bytes_sent < TotalBytes) begin
      case (phase)
        1:       width = WbW'(31);
        2:       width = WbW'(1);
        3:       width = WbW'(0);
        default: width = WbW'($urandom_range(0, 31));
      endcase
      write_width(width);
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      gapless = (phase % 4 == 0);
      // Fill the block: a long receiver hold-off while beats keep coming.
      if (phase == 2) begin
        gapless     = 1'b1;
        hold_cycles = HoldCycles;
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes && bytes_sent < TotalBytes)
        send_stream($urandom_range(1, 12), $urandom_range(0, 9) != 0);
      drain_block();
      phase++;
    end

    if (mismatches == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
